// ===== sv/calendar_date_engine_unit_macros.svh =====
// Assertion helpers for the RTL file that checks its own logic.
`ifndef CALENDAR_DATE_ENGINE_UNIT_MACROS_SVH
`define CALENDAR_DATE_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDE_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cde_pkg.sv =====
`default_nettype none
package cde_pkg;

  localparam int BASE_YEAR_INT = 1970;
  localparam logic [11:0] BASE_YEAR = 12'd1970;
  localparam int YEAR_SPAN_DEF = 256;

  localparam int YOFF_W = 8;
  localparam int CNT_W = 17;
  localparam int AMT_W = 18;
  localparam int ACC_W = 20;

  localparam logic [2:0] ACT_SET = 3'd0;
  localparam logic [2:0] ACT_ADD_DAYS = 3'd1;
  localparam logic [2:0] ACT_ADD_MONTHS = 3'd2;
  localparam logic [2:0] ACT_ADD_YEARS = 3'd3;
  localparam logic [2:0] ACT_QUERY = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_YEAR_LOW = 2'd1;
  localparam logic [1:0] ST_BAD_DATE = 2'd2;
  localparam logic [1:0] ST_SPAN = 2'd3;

  localparam logic CFG_DEFAULT_MONTH = 1'b0;
  localparam logic CFG_DEFAULT_DAY = 1'b1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] FEB_SHORT = 5'd28;

  // Year offsets from 1970 of the century years 2100 and 2200, which are not leap years.
  localparam logic [7:0] SKIP_2100 = 8'd130;
  localparam logic [7:0] SKIP_2200 = 8'd230;

  // 1970-01-01 was a Thursday.
  localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
  } cde_cfg_t;

  typedef struct packed {
    logic signed [AMT_W-1:0] amount;
    logic [4:0]              day;
    logic [3:0]              month;
    logic [11:0]             year;
    logic [2:0]              action;
  } cde_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] day_count;
    logic [2:0]       weekday;
    logic [4:0]       day;
    logic [3:0]       month;
    logic [11:0]      year;
  } cde_result_t;

  function automatic logic is_leap_off(logic [YOFF_W-1:0] k);
    return (k[1:0] == 2'b10) && (k != SKIP_2100) && (k != SKIP_2200);
  endfunction

  function automatic logic [8:0] year_len(logic [YOFF_W-1:0] k);
    return is_leap_off(k) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(logic [YOFF_W-1:0] k, logic [3:0] m);
    logic [4:0] len;
    if (m == MONTH_FEB) begin
      len = is_leap_off(k) ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = 5'd31;
    end else begin
      len = 5'd0;
    end
    return len;
  endfunction

  function automatic int span_last(int span);
    int total;
    total = 0;
    for (int k = 0; k < span; k++) begin
      total += int'(year_len(YOFF_W'(k)));
    end
    return total - 1;
  endfunction

endpackage
`default_nettype wire

// ===== sv/cde_alu.sv =====
`default_nettype none
module cde_alu
  import cde_pkg::*;
(
  input  wire logic [ACC_W-1:0] a_i,
  input  wire logic [ACC_W-1:0] b_i,
  input  wire logic             sub_i,
  output logic      [ACC_W-1:0] y_o,
  output logic                  ge_o
);

  assign y_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign ge_o = !y_o[ACC_W-1];

endmodule
`default_nettype wire

// ===== sv/cde_core.sv =====
`default_nettype none
module cde_core
  import cde_pkg::*;
#(
  parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cde_cfg_t    cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire cde_item_t   in_item_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output cde_result_t      res_o
);

  localparam int LAST = span_last(YEAR_SPAN);
  localparam logic [12:0] YEAR_END = 13'(BASE_YEAR_INT + YEAR_SPAN);
  localparam logic [ACC_W-1:0] MIDX_END = ACC_W'(YEAR_SPAN * 12);
  localparam logic [YOFF_W-1:0] YOFF_LAST = YOFF_W'(YEAR_SPAN - 1);
  // The month index stays below 3072, where this reciprocal gives the exact quotient by 12.
  localparam logic [11:0] DIV12_RECIP = 12'd2731;
  localparam int DIV12_SHIFT = 15;
  // Seven folds of the low three bits onto the rest bring an 18-bit count below eight.
  localparam logic [3:0] MOD7_TOP = 4'd6;

  typedef enum logic [15:0] {
    S_IDLE      = 16'b0000000000000001,
    S_LOAD      = 16'b0000000000000010,
    S_MI_A      = 16'b0000000000000100,
    S_MI_B      = 16'b0000000000001000,
    S_MI_C      = 16'b0000000000010000,
    S_DIV12     = 16'b0000000000100000,
    S_MREM_A    = 16'b0000000001000000,
    S_MREM_B    = 16'b0000000010000000,
    S_MCLAMP    = 16'b0000000100000000,
    S_TC_YEAR   = 16'b0000001000000000,
    S_TC_MON    = 16'b0000010000000000,
    S_TC_DAY    = 16'b0000100000000000,
    S_FC_YEAR   = 16'b0001000000000000,
    S_FC_MON    = 16'b0010000000000000,
    S_MOD7      = 16'b0100000000000000,
    S_DONE      = 16'b1000000000000000
  } cde_state_e;

  cde_state_e state_q, state_d;
  logic             weekday_init_q, weekday_init_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [YOFF_W-1:0] yoff_q, yoff_d;
  logic [3:0]       mon_q, mon_d;
  logic [4:0]       day_q, day_d;
  logic [2:0]       wd_q, wd_d;

  cde_item_t         item_q, item_d;
  logic [1:0]        status_q, status_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [YOFF_W-1:0] it_q, it_d;
  logic [3:0]        mi_q, mi_d;
  logic [3:0]        step_q, step_d;
  logic [YOFF_W-1:0] quo_q, quo_d;
  logic [YOFF_W-1:0] tgt_y_q, tgt_y_d;
  logic [3:0]        tgt_m_q, tgt_m_d;
  logic [4:0]        tgt_d_q, tgt_d_d;

  logic [ACC_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub, alu_ge;
  logic [ACC_W-1:0] amt_ext;
  logic [3:0]       set_m;
  logic [4:0]       set_d;
  logic [11:0]      set_ydiff;
  logic [YOFF_W-1:0] set_yoff;
  logic [3:0]       clamp_m;
  logic [4:0]       clamp_lim;
  logic [23:0]      div12_prod;

  cde_alu u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .y_o  (alu_y),
    .ge_o (alu_ge)
  );

  assign amt_ext = {{(ACC_W-AMT_W){item_q.amount[AMT_W-1]}}, item_q.amount};
  assign set_m = (item_q.month == 4'd0) ? cfg_i.month : item_q.month;
  assign set_d = (item_q.day == 5'd0) ? cfg_i.day : item_q.day;
  assign set_ydiff = item_q.year - BASE_YEAR;
  assign set_yoff = set_ydiff[YOFF_W-1:0];
  assign clamp_m = acc_q[3:0] + 4'd1;
  assign clamp_lim = month_len(quo_q, clamp_m);
  assign div12_prod = {12'b0, acc_q[11:0]} * {12'b0, DIV12_RECIP};

  always_comb begin
    alu_a = acc_q;
    alu_b = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_LOAD: begin
        if (item_q.action == ACT_ADD_DAYS) begin
          alu_a = {{(ACC_W-CNT_W){1'b0}}, cnt_q};
        end else begin
          alu_a = {{(ACC_W-YOFF_W){1'b0}}, yoff_q};
        end
        alu_b = amt_ext;
      end
      S_MI_A: begin
        alu_a = {{(ACC_W-YOFF_W-3){1'b0}}, yoff_q, 3'b000};
        alu_b = {{(ACC_W-YOFF_W-2){1'b0}}, yoff_q, 2'b00};
      end
      S_MI_B: alu_b = {{(ACC_W-4){1'b0}}, mon_q - 4'd1};
      S_MI_C: alu_b = amt_ext;
      S_MREM_A: begin
        alu_b = {{(ACC_W-YOFF_W-3){1'b0}}, quo_q, 3'b000};
        alu_sub = 1'b1;
      end
      S_MREM_B: begin
        alu_b = {{(ACC_W-YOFF_W-2){1'b0}}, quo_q, 2'b00};
        alu_sub = 1'b1;
      end
      S_TC_YEAR: alu_b = {{(ACC_W-9){1'b0}}, year_len(it_q)};
      S_TC_MON: alu_b = {{(ACC_W-5){1'b0}}, month_len(tgt_y_q, mi_q)};
      S_TC_DAY: alu_b = {{(ACC_W-5){1'b0}}, tgt_d_q - 5'd1};
      S_FC_YEAR: begin
        alu_b = {{(ACC_W-9){1'b0}}, year_len(it_q)};
        alu_sub = 1'b1;
      end
      S_FC_MON: begin
        alu_b = {{(ACC_W-5){1'b0}}, month_len(it_q, mi_q)};
        alu_sub = 1'b1;
      end
      S_MOD7: begin
        if (weekday_init_q) begin
          alu_a = {{(ACC_W-CNT_W){1'b0}}, cnt_q};
          alu_b = {{(ACC_W-3){1'b0}}, EPOCH_WEEKDAY};
        end else begin
          alu_a = {{(ACC_W-3){1'b0}}, acc_q[2:0]};
          alu_b = {3'b000, acc_q[ACC_W-1:3]};
        end
      end
      default: alu_b = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    weekday_init_d = weekday_init_q;
    cnt_d = cnt_q;
    yoff_d = yoff_q;
    mon_d = mon_q;
    day_d = day_q;
    wd_d = wd_q;
    item_d = item_q;
    status_d = status_q;
    acc_d = acc_q;
    it_d = it_q;
    mi_d = mi_q;
    step_d = step_q;
    quo_d = quo_q;
    tgt_y_d = tgt_y_q;
    tgt_m_d = tgt_m_q;
    tgt_d_d = tgt_d_q;
    in_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_item_i;
          status_d = ST_OK;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        acc_d = '0;
        it_d = '0;
        case (item_q.action)
          ACT_SET: begin
            if (item_q.year < BASE_YEAR) begin
              status_d = ST_YEAR_LOW;
            end else if ({1'b0, item_q.year} >= YEAR_END) begin
              status_d = ST_SPAN;
            end else if (set_m == 4'd0 || set_m > MONTH_DEC || set_d == 5'd0 ||
                         set_d > month_len(set_yoff, set_m)) begin
              status_d = ST_BAD_DATE;
            end
            if (item_q.year < BASE_YEAR || {1'b0, item_q.year} >= YEAR_END ||
                set_m == 4'd0 || set_m > MONTH_DEC || set_d == 5'd0 ||
                set_d > month_len(set_yoff, set_m)) begin
              state_d = S_DONE;
            end else begin
              tgt_y_d = set_yoff;
              tgt_m_d = set_m;
              tgt_d_d = set_d;
              state_d = S_TC_YEAR;
            end
          end
          ACT_ADD_DAYS: begin
            if (alu_y[ACC_W-1] || alu_y > ACC_W'(LAST)) begin
              status_d = ST_SPAN;
              state_d = S_DONE;
            end else begin
              cnt_d = alu_y[CNT_W-1:0];
              acc_d = alu_y;
              state_d = S_FC_YEAR;
            end
          end
          ACT_ADD_MONTHS: state_d = S_MI_A;
          ACT_ADD_YEARS: begin
            if (alu_y[ACC_W-1] || alu_y >= ACC_W'(YEAR_SPAN)) begin
              status_d = ST_SPAN;
              state_d = S_DONE;
            end else begin
              tgt_y_d = alu_y[YOFF_W-1:0];
              tgt_m_d = mon_q;
              if (mon_q == MONTH_FEB && day_q > FEB_SHORT &&
                  !is_leap_off(alu_y[YOFF_W-1:0])) begin
                tgt_d_d = FEB_SHORT;
              end else begin
                tgt_d_d = day_q;
              end
              state_d = S_TC_YEAR;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_MI_A: begin
        acc_d = alu_y;
        state_d = S_MI_B;
      end
      S_MI_B: begin
        acc_d = alu_y;
        state_d = S_MI_C;
      end
      S_MI_C: begin
        if (alu_y[ACC_W-1] || alu_y >= MIDX_END) begin
          status_d = ST_SPAN;
          state_d = S_DONE;
        end else begin
          acc_d = alu_y;
          state_d = S_DIV12;
        end
      end
      S_DIV12: begin
        quo_d = div12_prod[DIV12_SHIFT +: YOFF_W];
        state_d = S_MREM_A;
      end
      S_MREM_A: begin
        acc_d = alu_y;
        state_d = S_MREM_B;
      end
      S_MREM_B: begin
        acc_d = alu_y;
        state_d = S_MCLAMP;
      end
      S_MCLAMP: begin
        tgt_y_d = quo_q;
        tgt_m_d = clamp_m;
        tgt_d_d = (day_q > clamp_lim) ? clamp_lim : day_q;
        acc_d = '0;
        it_d = '0;
        state_d = S_TC_YEAR;
      end
      S_TC_YEAR: begin
        if (it_q == tgt_y_q) begin
          mi_d = MONTH_JAN;
          state_d = S_TC_MON;
        end else begin
          acc_d = alu_y;
          it_d = it_q + YOFF_W'(1);
        end
      end
      S_TC_MON: begin
        if (mi_q == tgt_m_q) begin
          state_d = S_TC_DAY;
        end else begin
          acc_d = alu_y;
          mi_d = mi_q + 4'd1;
        end
      end
      S_TC_DAY: begin
        cnt_d = alu_y[CNT_W-1:0];
        yoff_d = tgt_y_q;
        mon_d = tgt_m_q;
        day_d = tgt_d_q;
        weekday_init_d = 1'b1;
        state_d = S_MOD7;
      end
      S_FC_YEAR: begin
        if (it_q != YOFF_LAST && alu_ge) begin
          acc_d = alu_y;
          it_d = it_q + YOFF_W'(1);
        end else begin
          mi_d = MONTH_JAN;
          state_d = S_FC_MON;
        end
      end
      S_FC_MON: begin
        if (mi_q != MONTH_DEC && alu_ge) begin
          acc_d = alu_y;
          mi_d = mi_q + 4'd1;
        end else begin
          yoff_d = it_q;
          mon_d = mi_q;
          day_d = acc_q[4:0] + 5'd1;
          weekday_init_d = 1'b1;
          state_d = S_MOD7;
        end
      end
      S_MOD7: begin
        acc_d = alu_y;
        if (weekday_init_q) begin
          step_d = MOD7_TOP;
          weekday_init_d = 1'b0;
        end else if (step_q == 4'd0) begin
          wd_d = (alu_y[2:0] == 3'd7) ? 3'd0 : alu_y[2:0];
          state_d = S_DONE;
        end else begin
          step_d = step_q - 4'd1;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.status = status_q;
  assign res_o.day_count = cnt_q;
  assign res_o.weekday = wd_q;
  assign res_o.day = day_q;
  assign res_o.month = mon_q;
  assign res_o.year = BASE_YEAR + {{(12-YOFF_W){1'b0}}, yoff_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      weekday_init_q <= 1'b0;
      cnt_q <= '0;
      yoff_q <= '0;
      mon_q <= MONTH_JAN;
      day_q <= 5'd1;
      wd_q <= EPOCH_WEEKDAY;
    end else begin
      state_q <= state_d;
      weekday_init_q <= weekday_init_d;
      cnt_q <= cnt_d;
      yoff_q <= yoff_d;
      mon_q <= mon_d;
      day_q <= day_d;
      wd_q <= wd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    status_q <= status_d;
    acc_q <= acc_d;
    it_q <= it_d;
    mi_q <= mi_d;
    step_q <= step_d;
    quo_q <= quo_d;
    tgt_y_q <= tgt_y_d;
    tgt_m_q <= tgt_m_d;
    tgt_d_q <= tgt_d_d;
  end

endmodule
`default_nettype wire

// ===== sv/calendar_date_engine_unit.sv =====
// Calendar date engine: holds one Gregorian date as a day count since 1970-01-01.
// Input beats on s_axis carry an action (set, add days, add months, add years,
// query) with its operands; every input beat yields exactly one result beat on
// m_axis with the stored date as year, month, day, weekday and day count plus a
// status code. Errors leave the stored date untouched and are reported in status.
// The cfg port writes the default month and day used by a set action.
// An item is taken only while the engine is idle; it then works alone on it.
// A query or a rejected set, add of days or add of years needs only its load step
// before the result is offered; a rejected add of months first forms its month index.
// A conversion walks one year per cycle through the shared adder, then one month per
// cycle, then folds the day count for the weekday; an add of months first splits its
// month index into year and month. The engine is ready again as soon as its result
// enters the output register. The result sits in an output register, so the next
// item may be accepted while the receiver stalls; a second result waits in the
// engine until that register drains. Reset restores 1970-01-01 and sets both
// defaults to one.
`default_nettype none
`include "calendar_date_engine_unit_macros.svh"
module calendar_date_engine_unit
  import cde_pkg::*;
#(
  parameter int YEAR_SPAN = YEAR_SPAN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action[2:0], year_in[14:3], month_in[18:15], day_in[23:19], amount[41:24], zeros
  input  wire logic [47:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // year_out[11:0], month_out[15:12], day_out[20:16], weekday[23:21],
  // day_count[40:24], status[42:41], zeros
  output logic      [47:0] m_axis_tdata
);

  localparam int LAST = span_last(YEAR_SPAN);

  cde_cfg_t    cfg_q, cfg_d;
  cde_item_t   in_item;
  cde_result_t res, out_q;
  logic        out_valid_q, out_valid_d;
  logic        res_valid, res_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEFAULT_MONTH: cfg_d.month = cfg_data_i[3:0];
        CFG_DEFAULT_DAY: cfg_d.day = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign in_item.action = s_axis_tdata[2:0];
  assign in_item.year = s_axis_tdata[14:3];
  assign in_item.month = s_axis_tdata[18:15];
  assign in_item.day = s_axis_tdata[23:19];
  assign in_item.amount = s_axis_tdata[41:24];

  cde_core #(
    .YEAR_SPAN(YEAR_SPAN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.month <= MONTH_JAN;
      cfg_q.day <= 5'd1;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {5'b0, out_q.status, out_q.day_count, out_q.weekday,
                         out_q.day, out_q.month, out_q.year};

  `CDE_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while busy")
  `CDE_ASSERT_HOLDS(a_count_span, m_axis_tvalid, out_q.day_count <= CNT_W'(LAST), "count past span")
  `CDE_ASSERT_HOLDS(a_month_ok, m_axis_tvalid, out_q.month >= MONTH_JAN && out_q.month <= MONTH_DEC, "bad month")
  `CDE_ASSERT_HOLDS(a_day_ok, m_axis_tvalid, out_q.day != 5'd0 && out_q.weekday != 3'd7, "bad day")

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
  import cde_pkg::*;

  localparam int SPAN_YEARS = 256;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int DRAIN_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  typedef struct {
    cde_item_t   beat;
    bit          typed;
    cde_result_t want;
  } vector_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  int held_count = 0;
  int dflt_month = 1;
  int dflt_day = 1;
  int last_count = 0;
  cde_result_t pending_dates[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int rx_left = 0;
  int rx_kind = 0;

  calendar_date_engine_unit #(
    .YEAR_SPAN(SPAN_YEARS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit leap_year(int y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic int month_days(int y, int m);
    int len;
    case (m)
      2: len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      1, 3, 5, 7, 8, 10, 12: len = 31;
      default: len = 0;
    endcase
    return len;
  endfunction

  function automatic int count_of(int y, int m, int d);
    int c;
    c = 0;
    for (int i = BASE_YEAR_INT; i < y; i++) begin
      c += leap_year(i) ? 366 : 365;
    end
    for (int i = 1; i < m; i++) begin
      c += month_days(y, i);
    end
    return c + d - 1;
  endfunction

  function automatic void split_count(input int c, output int y, output int m, output int d);
    int rest;
    rest = c;
    y = BASE_YEAR_INT;
    m = 1;
    while (y < BASE_YEAR_INT + SPAN_YEARS - 1 && rest >= (leap_year(y) ? 366 : 365)) begin
      rest -= leap_year(y) ? 366 : 365;
      y++;
    end
    while (m < 12 && rest >= month_days(y, m)) begin
      rest -= month_days(y, m);
      m++;
    end
    d = rest + 1;
  endfunction

  function automatic int weekday_of(int y, int m, int d);
    int yy;
    int cen;
    int w;
    if (m <= 2) begin
      m += 12;
      y -= 1;
    end
    yy = y % 100;
    cen = y / 100;
    w = (yy + yy / 4 + cen / 4 - 2 * cen + (13 * (m + 1)) / 5 + d - 1) % 7;
    if (w < 0) begin
      w += 7;
    end
    return w;
  endfunction

  // Applies one action to the held date and returns the result beat it should produce.
  function automatic cde_result_t advance_date(cde_item_t it);
    int y;
    int m;
    int d;
    int nc;
    int mm;
    int dd;
    int amt;
    int idx;
    int ny;
    int nm;
    int lim;
    int yin;
    logic [1:0] st;
    cde_result_t res;
    amt = $signed(it.amount);
    yin = it.year;
    split_count(held_count, y, m, d);
    st = ST_OK;
    nc = -1;
    case (it.action)
      ACT_SET: begin
        mm = (it.month != 0) ? int'(it.month) : dflt_month;
        dd = (it.day != 0) ? int'(it.day) : dflt_day;
        if (yin < BASE_YEAR_INT) begin
          st = ST_YEAR_LOW;
        end else if (yin >= BASE_YEAR_INT + SPAN_YEARS) begin
          st = ST_SPAN;
        end else if (mm < 1 || mm > 12 || dd < 1 || dd > month_days(yin, mm)) begin
          st = ST_BAD_DATE;
        end else begin
          nc = count_of(yin, mm, dd);
        end
      end
      ACT_ADD_DAYS: begin
        nc = held_count + amt;
        if (nc < 0 || nc > last_count) begin
          st = ST_SPAN;
        end
      end
      ACT_ADD_MONTHS: begin
        idx = (y - BASE_YEAR_INT) * 12 + (m - 1) + amt;
        if (idx < 0 || idx >= SPAN_YEARS * 12) begin
          st = ST_SPAN;
        end else begin
          ny = BASE_YEAR_INT + idx / 12;
          nm = idx % 12 + 1;
          lim = month_days(ny, nm);
          nc = count_of(ny, nm, (d > lim) ? lim : d);
        end
      end
      ACT_ADD_YEARS: begin
        ny = y + amt;
        if (ny < BASE_YEAR_INT || ny >= BASE_YEAR_INT + SPAN_YEARS) begin
          st = ST_SPAN;
        end else begin
          dd = (m == 2 && d > 28 && !leap_year(ny)) ? 28 : d;
          nc = count_of(ny, m, dd);
        end
      end
      default: begin
      end
    endcase
    if (st == ST_OK && nc >= 0) begin
      held_count = nc;
      split_count(held_count, y, m, d);
    end
    res.year = 12'(y);
    res.month = 4'(m);
    res.day = 5'(d);
    res.weekday = 3'(weekday_of(y, m, d));
    res.day_count = CNT_W'(held_count);
    res.status = st;
    return res;
  endfunction

  function automatic vector_row_t mk_row(logic [2:0] act, int yr, int mo, int dy, int amt,
                                         bit typed, int ey, int em, int ed, int ew, int ec,
                                         logic [1:0] es);
    vector_row_t r;
    r.beat.action = act;
    r.beat.year = 12'(yr);
    r.beat.month = 4'(mo);
    r.beat.day = 5'(dy);
    r.beat.amount = 18'(amt);
    r.typed = typed;
    r.want.year = 12'(ey);
    r.want.month = 4'(em);
    r.want.day = 5'(ed);
    r.want.weekday = 3'(ew);
    r.want.day_count = CNT_W'(ec);
    r.want.status = es;
    return r;
  endfunction

  task automatic log_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic send_beat(vector_row_t r);
    int gap;
    cde_result_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0
          : $urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 4);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= 48'(r.beat);
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    pred = advance_date(r.beat);
    pending_dates.push_back(r.typed ? r.want : pred);
  endtask

  task automatic settle_engine();
    s_axis_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(logic idx, logic [4:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_DEFAULT_MONTH) begin
      dflt_month = value[3:0];
    end else begin
      dflt_day = value;
    end
  endtask

  // A random mix of mostly well-formed sets, moves and queries, with some out-of-range noise mixed in.
  task automatic run_phase(int count);
    vector_row_t r;
    logic [63:0] bits;
    int pick;
    int sel;
    int yr;
    int mo;
    int dy;
    int amt;
    for (int i = 0; i < count; i++) begin
      bits = {$urandom(), $urandom()};
      r.beat = bits[41:0];
      r.typed = 1'b0;
      r.want = '0;
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 9);
      if (pick < 30) begin
        r.beat.action = ACT_SET;
        if (sel < 8) begin
          yr = $urandom_range(1970, 2225);
        end else if (sel == 8) begin
          yr = $urandom_range(0, 4095);
        end else begin
          yr = $urandom_range(0, 1) ? 1969 + $urandom_range(0, 1) : 2225 + $urandom_range(0, 1);
        end
        sel = $urandom_range(0, 9);
        mo = (sel < 8) ? $urandom_range(1, 12) : (sel == 8) ? 0 : $urandom_range(13, 15);
        sel = $urandom_range(0, 9);
        if (mo >= 1 && mo <= 12 && sel < 7) begin
          dy = $urandom_range(1, month_days(yr, mo));
        end else if (sel == 7) begin
          dy = 0;
        end else begin
          dy = $urandom_range(1, 31);
        end
        r.beat.year = 12'(yr);
        r.beat.month = 4'(mo);
        r.beat.day = 5'(dy);
      end else if (pick < 50) begin
        r.beat.action = ACT_ADD_DAYS;
        if (sel < 6) begin
          amt = int'($urandom_range(0, 800)) - 400;
          r.beat.amount = 18'(amt);
        end else if (sel < 9) begin
          amt = int'($urandom_range(0, 80000)) - 40000;
          r.beat.amount = 18'(amt);
        end
      end else if (pick < 70) begin
        r.beat.action = ACT_ADD_MONTHS;
        if (sel < 7) begin
          amt = int'($urandom_range(0, 72)) - 36;
          r.beat.amount = 18'(amt);
        end else if (sel < 9) begin
          amt = int'($urandom_range(0, 6200)) - 3100;
          r.beat.amount = 18'(amt);
        end
      end else if (pick < 85) begin
        r.beat.action = ACT_ADD_YEARS;
        if (sel < 7) begin
          amt = int'($urandom_range(0, 40)) - 20;
          r.beat.amount = 18'(amt);
        end else if (sel < 9) begin
          amt = int'($urandom_range(0, 520)) - 260;
          r.beat.amount = 18'(amt);
        end
      end else if (pick < 95) begin
        r.beat.action = ACT_QUERY;
      end else begin
        sel = $urandom_range(0, 2);
        r.beat.action = (sel == 0) ? ACT_SPARE_5 : (sel == 1) ? ACT_SPARE_6 : ACT_SPARE_7;
      end
      send_beat(r);
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_kind = $urandom_range(0, 2);
      rx_left = (rx_kind == 0) ? $urandom_range(10, 60)
              : (rx_kind == 1) ? $urandom_range(1, 24) : $urandom_range(10, 40);
    end
    rx_left--;
    case (rx_kind)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'b0;
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk_i) begin
    cde_result_t got;
    cde_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(cde_result_t)-1:0];
      if (pending_dates.size() == 0) begin
        log_error("result beat arrived with nothing pending");
      end else begin
        want = pending_dates.pop_front();
        if (got.year !== want.year)
          log_error($sformatf("year expected %0d got %0d", want.year, got.year));
        if (got.month !== want.month)
          log_error($sformatf("month expected %0d got %0d", want.month, got.month));
        if (got.day !== want.day)
          log_error($sformatf("day expected %0d got %0d", want.day, got.day));
        if (got.weekday !== want.weekday)
          log_error($sformatf("weekday expected %0d got %0d", want.weekday, got.weekday));
        if (got.day_count !== want.day_count)
          log_error($sformatf("day_count expected %0d got %0d", want.day_count, got.day_count));
        if (got.status !== want.status)
          log_error($sformatf("status expected %0d got %0d", want.status, got.status));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    vector_row_t rows[$];
    logic [4:0] new_month;
    logic [4:0] new_day;
    last_count = count_of(BASE_YEAR_INT + SPAN_YEARS - 1, 12, 31);

    // Errors leave the epoch date in place, so those rows can be written out directly.
    rows.push_back(mk_row(ACT_QUERY, 0, 0, 0, 0, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_OK));
    rows.push_back(mk_row(ACT_SET, 1969, 1, 1, 0, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_YEAR_LOW));
    rows.push_back(mk_row(ACT_SET, 0, 0, 0, 0, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_YEAR_LOW));
    rows.push_back(mk_row(ACT_SET, 4095, 15, 31, -1, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_SPAN));
    rows.push_back(mk_row(ACT_SET, 1970, 13, 1, 0, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_BAD_DATE));
    rows.push_back(mk_row(ACT_SET, 1970, 2, 29, 0, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_BAD_DATE));
    rows.push_back(mk_row(ACT_SET, 1970, 0, 0, 0, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_DAYS, 0, 0, 0, -1, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0, ST_SPAN));
    rows.push_back(mk_row(ACT_ADD_DAYS, 0, 0, 0, 131071, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0,
                          ST_SPAN));
    rows.push_back(mk_row(ACT_ADD_DAYS, 0, 0, 0, -131072, 1, 1970, 1, 1, EPOCH_WEEKDAY, 0,
                          ST_SPAN));
    rows.push_back(mk_row(ACT_SET, 2225, 12, 31, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_DAYS, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_DAYS, 0, 0, 0, -93501, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_SET, 2000, 2, 29, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_YEARS, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_SET, 2000, 1, 31, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_MONTHS, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_MONTHS, 0, 0, 0, -131072, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_MONTHS, 0, 0, 0, 131071, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_YEARS, 0, 0, 0, 256, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_YEARS, 0, 0, 0, -131072, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_SPARE_5, 4095, 15, 31, -1, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_SPARE_6, 1990, 5, 5, 5, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_SPARE_7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_SET, 2100, 2, 29, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_SET, 2225, 12, 1, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_MONTHS, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk_row(ACT_ADD_MONTHS, 0, 0, 0, -3071, 0, 0, 0, 0, 0, 0, ST_OK));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_beat(rows[i]);
    end
    settle_engine();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          new_month = 5'd12;
          new_day = 5'd31;
        end
        1: begin
          new_month = 5'd0;
          new_day = 5'd0;
        end
        2: begin
          new_month = 5'd15;
          new_day = 5'd31;
        end
        3: begin
          new_month = 5'($urandom_range(0, 15));
          new_day = 5'($urandom_range(0, 31));
        end
        default: begin
          new_month = 5'd2;
          new_day = 5'd29;
        end
      endcase
      write_reg(CFG_DEFAULT_MONTH, new_month);
      write_reg(CFG_DEFAULT_DAY, new_day);
      cfg_we_i <= 1'b0;
      run_phase(ITEMS_PER_PHASE);
      settle_engine();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
